// ===== src/pbpc_pkg.sv =====
package pbpc_pkg;

  localparam int CORDIC_STAGES    = 16;
  localparam int ERROR_DIMENSIONS = 8;
  localparam int SQRT_STEPS       = 32;
  localparam int DIV_STEPS        = 15;

  localparam int ST_IN   = 0;
  localparam int ST_PRE  = 1;
  localparam int ST_COR0 = 2;
  localparam int ST_K1   = ST_COR0 + CORDIC_STAGES;
  localparam int ST_K2   = ST_K1 + 1;
  localparam int ST_K3   = ST_K2 + 1;
  localparam int ST_K4   = ST_K3 + 1;
  localparam int ST_SQ0  = ST_K4 + 1;
  localparam int ST_DV0  = ST_SQ0 + SQRT_STEPS;
  localparam int ST_OUT  = ST_DV0 + DIV_STEPS;
  localparam int NSTG    = ST_OUT + 1;

  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [31:0] INV_GAIN    = 32'sd652032874;
  localparam logic signed [15:0] UNIT_Q14    = 16'sd16384;

  localparam logic [1:0] REG_GAIN_LINEAR  = 2'd0;
  localparam logic [1:0] REG_GAIN_ANGULAR = 2'd1;
  localparam logic [1:0] REG_TOLERANCE    = 2'd2;

  typedef struct packed {
    logic [7:0][15:0]        e;
    logic [15:0]             hd;
    logic [7:0][31:0]        sq;
    logic [3:0][32:0]        ps;
    logic                    reached;
    logic signed [35:0]      x;
    logic signed [35:0]      y;
    logic signed [33:0]      z;
    logic signed [15:0]      w;
    logic signed [55:0]      px;
    logic signed [55:0]      py;
    logic signed [42:0]      gx;
    logic signed [42:0]      gy;
    logic signed [31:0]      dx;
    logic signed [31:0]      dy;
    logic [63:0]             sqx;
    logic [63:0]             sqy;
    logic [63:0]             rem;
    logic [63:0]             root;
    logic                    big;
    logic [47:0]             rx;
    logic [47:0]             ry;
    logic [14:0]             qx;
    logic [14:0]             qy;
    logic                    sx;
    logic                    sy;
    logic [15:0]             vx;
    logic [15:0]             vy;
    logic [15:0]             ox;
    logic [15:0]             oy;
    logic [15:0]             ow;
  } pipe_t;

  function automatic logic signed [33:0] atan_q28(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sd210828714;
        1: r = 34'sd124459457;
        2: r = 34'sd65760959;
        3: r = 34'sd33381290;
        4: r = 34'sd16755422;
        5: r = 34'sd8385879;
        6: r = 34'sd4193963;
        7: r = 34'sd2097109;
        8: r = 34'sd1048571;
        9: r = 34'sd524287;
        default: r = 34'sd1 <<< (28 - i);
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/planar_base_p_controller_unit.sv =====
// pipeline: cordic 16 stages, isqrt 32 stages, two 15-step restoring dividers,
// plus input, pre, scaling and output stages
// throughput: one transfer per cycle; a stalled output holds the whole pipeline,
// but an empty input stage still takes a transfer
// reset: asynchronous active low, clears valid bits and restores the gain and tolerance registers
module planar_base_p_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // error_x, error_y, error_heading, heading_now, joint_error_one..five
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // velocity_x, velocity_y, turn_rate
  output logic [47:0]  m_axis_tdata,
  // goal_reached
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int N = pbpc_pkg::NSTG;

  logic [15:0] gain_lin_q, gain_ang_q;
  logic [31:0] tol_q;

  pbpc_pkg::pipe_t pipe_q [N];
  pbpc_pkg::pipe_t pipe_d [N];
  logic [N-1:0]    valid_q;
  logic            adv;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_lin_q <= 16'd2560;
      gain_ang_q <= 16'd2560;
      tol_q      <= 32'd167772;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        pbpc_pkg::REG_GAIN_LINEAR:  gain_lin_q <= pwdata[15:0];
        pbpc_pkg::REG_GAIN_ANGULAR: gain_ang_q <= pwdata[15:0];
        pbpc_pkg::REG_TOLERANCE:    tol_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pbpc_pkg::REG_GAIN_LINEAR:  prdata = {16'd0, gain_lin_q};
      pbpc_pkg::REG_GAIN_ANGULAR: prdata = {16'd0, gain_ang_q};
      pbpc_pkg::REG_TOLERANCE:    prdata = tol_q;
      default:                    prdata = 32'd0;
    endcase
  end

  assign adv           = !valid_q[N-1] || m_axis_tready;
  assign s_axis_tready = adv || !valid_q[0];

  always_comb begin : st_in
    pbpc_pkg::pipe_t p;
    p      = '0;
    p.e[0] = s_axis_tdata[15:0];
    p.e[1] = s_axis_tdata[31:16];
    p.e[2] = s_axis_tdata[47:32];
    p.hd   = s_axis_tdata[63:48];
    p.e[3] = s_axis_tdata[79:64];
    p.e[4] = s_axis_tdata[95:80];
    p.e[5] = s_axis_tdata[111:96];
    p.e[6] = s_axis_tdata[127:112];
    p.e[7] = s_axis_tdata[143:128];
    pipe_d[0] = p;
  end

  for (genvar k = 1; k < N; k++) begin : g_st
    if (k == pbpc_pkg::ST_PRE) begin : g_pre
      always_comb begin : pre
        pbpc_pkg::pipe_t    p;
        logic signed [35:0] x0, y0;
        logic signed [33:0] z0;
        logic signed [32:0] wp;
        logic signed [26:0] ws;
        p  = pipe_q[k-1];
        for (int i = 0; i < 8; i++) begin
          if (i < pbpc_pkg::ERROR_DIMENSIONS) begin
            p.sq[i] = 32'($signed(p.e[i]) * $signed(p.e[i]));
          end else begin
            p.sq[i] = 32'd0;
          end
        end
        x0 = 36'($signed(p.e[0])) <<< 16;
        y0 = 36'($signed(p.e[1])) <<< 16;
        z0 = -(34'($signed(p.hd)) <<< 16);
        if (z0 > pbpc_pkg::ANG_PI) begin
          z0 = z0 - pbpc_pkg::ANG_TWO_PI;
        end else if (z0 < -pbpc_pkg::ANG_PI) begin
          z0 = z0 + pbpc_pkg::ANG_TWO_PI;
        end
        if (z0 > pbpc_pkg::ANG_HALF_PI) begin
          p.x = -y0;
          p.y = x0;
          p.z = z0 - pbpc_pkg::ANG_HALF_PI;
        end else if (z0 < -pbpc_pkg::ANG_HALF_PI) begin
          p.x = y0;
          p.y = -x0;
          p.z = z0 + pbpc_pkg::ANG_HALF_PI;
        end else begin
          p.x = x0;
          p.y = y0;
          p.z = z0;
        end
        wp = $signed(p.e[2]) * $signed({1'b0, gain_ang_q});
        ws = 27'(wp >>> 6);
        if (ws > 27'(pbpc_pkg::UNIT_Q14)) begin
          p.w = pbpc_pkg::UNIT_Q14;
        end else if (ws < -27'(pbpc_pkg::UNIT_Q14)) begin
          p.w = -pbpc_pkg::UNIT_Q14;
        end else begin
          p.w = ws[15:0];
        end
        pipe_d[k] = p;
      end
    end else if (k >= pbpc_pkg::ST_COR0 && k < pbpc_pkg::ST_K1) begin : g_cor
      localparam int I = k - pbpc_pkg::ST_COR0;
      always_comb begin : cor
        pbpc_pkg::pipe_t    p;
        logic signed [35:0] xs, ys;
        logic [34:0]        tot;
        p  = pipe_q[k-1];
        xs = p.x >>> I;
        ys = p.y >>> I;
        if (p.z >= 0) begin
          p.x = p.x - ys;
          p.y = p.y + xs;
          p.z = p.z - pbpc_pkg::atan_q28(I);
        end else begin
          p.x = p.x + ys;
          p.y = p.y - xs;
          p.z = p.z + pbpc_pkg::atan_q28(I);
        end
        // squared norm summed over the first two rotation stages
        tot = 35'(p.ps[0]) + 35'(p.ps[1]) + 35'(p.ps[2]) + 35'(p.ps[3]);
        if (I == 0) begin
          for (int j = 0; j < 4; j++) begin
            p.ps[j] = 33'(p.sq[2*j]) + 33'(p.sq[2*j+1]);
          end
        end else if (I == 1) begin
          p.reached = tot < 35'(tol_q);
        end
        pipe_d[k] = p;
      end
    end else if (k == pbpc_pkg::ST_K1) begin : g_k1
      always_comb begin : k1
        pbpc_pkg::pipe_t p;
        p    = pipe_q[k-1];
        p.px = 56'(24'(p.x >>> 12) * pbpc_pkg::INV_GAIN);
        p.py = 56'(24'(p.y >>> 12) * pbpc_pkg::INV_GAIN);
        pipe_d[k] = p;
      end
    end else if (k == pbpc_pkg::ST_K2) begin : g_k2
      always_comb begin : k2
        pbpc_pkg::pipe_t p;
        p    = pipe_q[k-1];
        p.gx = 43'(26'(p.px >>> 30) * $signed({1'b0, gain_lin_q}));
        p.gy = 43'(26'(p.py >>> 30) * $signed({1'b0, gain_lin_q}));
        pipe_d[k] = p;
      end
    end else if (k == pbpc_pkg::ST_K3) begin : g_k3
      always_comb begin : k3
        pbpc_pkg::pipe_t p;
        p     = pipe_q[k-1];
        p.dx  = 32'(p.gx >>> 8);
        p.dy  = 32'(p.gy >>> 8);
        p.sqx = 64'(p.dx * p.dx);
        p.sqy = 64'(p.dy * p.dy);
        pipe_d[k] = p;
      end
    end else if (k == pbpc_pkg::ST_K4) begin : g_k4
      always_comb begin : k4
        pbpc_pkg::pipe_t p;
        logic [31:0]     ax, ay;
        p      = pipe_q[k-1];
        p.rem  = p.sqx + p.sqy;
        p.root = 64'd0;
        p.big  = p.rem > 64'h1_0000_0000;
        p.sx   = p.dx < 0;
        p.sy   = p.dy < 0;
        ax     = p.sx ? 32'(-p.dx) : 32'(p.dx);
        ay     = p.sy ? 32'(-p.dy) : 32'(p.dy);
        p.rx   = 48'(ax) << 14;
        p.ry   = 48'(ay) << 14;
        p.qx   = '0;
        p.qy   = '0;
        p.vx   = 16'(p.dx >>> 2);
        p.vy   = 16'(p.dy >>> 2);
        pipe_d[k] = p;
      end
    end else if (k >= pbpc_pkg::ST_SQ0 && k < pbpc_pkg::ST_DV0) begin : g_sq
      localparam int J = k - pbpc_pkg::ST_SQ0;
      always_comb begin : sq
        pbpc_pkg::pipe_t p;
        logic [63:0]     bt, trial;
        p     = pipe_q[k-1];
        bt    = 64'd1 << (62 - 2 * J);
        trial = p.root + bt;
        if (p.rem >= trial) begin
          p.rem  = p.rem - trial;
          p.root = (p.root >> 1) + bt;
        end else begin
          p.root = p.root >> 1;
        end
        pipe_d[k] = p;
      end
    end else if (k >= pbpc_pkg::ST_DV0 && k < pbpc_pkg::ST_OUT) begin : g_dv
      localparam int B = pbpc_pkg::DIV_STEPS - 1 - (k - pbpc_pkg::ST_DV0);
      always_comb begin : dv
        pbpc_pkg::pipe_t p;
        logic [47:0]     ds;
        p  = pipe_q[k-1];
        ds = 48'(p.root) << B;
        if (p.rx >= ds) begin
          p.rx    = p.rx - ds;
          p.qx[B] = 1'b1;
        end
        if (p.ry >= ds) begin
          p.ry    = p.ry - ds;
          p.qy[B] = 1'b1;
        end
        pipe_d[k] = p;
      end
    end else begin : g_out
      always_comb begin : fin
        pbpc_pkg::pipe_t p;
        p = pipe_q[k-1];
        if (p.reached) begin
          p.ox = '0;
          p.oy = '0;
          p.ow = '0;
        end else begin
          if (p.big) begin
            p.ox = p.sx ? -16'(p.qx) : 16'(p.qx);
            p.oy = p.sy ? -16'(p.qy) : 16'(p.qy);
          end else begin
            p.ox = p.vx;
            p.oy = p.vy;
          end
          p.ow = p.w;
        end
        pipe_d[k] = p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (s_axis_tready) begin
        valid_q[0] <= s_axis_tvalid;
      end
      if (adv) begin
        valid_q[N-1:1] <= valid_q[N-2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      pipe_q[0] <= pipe_d[0];
    end
    if (adv) begin
      for (int k = 1; k < N; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign m_axis_tvalid = valid_q[N-1];
  assign m_axis_tdata  = {pipe_q[N-1].ow, pipe_q[N-1].oy, pipe_q[N-1].ox};
  assign m_axis_tuser  = pipe_q[N-1].reached;

  a_reached_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 48'd0))
    else $error("goal reached with nonzero command");

  a_turn_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[47:32]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("turn rate out of range");

  a_ready_only_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input blocked without output stall");

  a_quot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[N-2] && pipe_q[N-2].big) |-> (pipe_q[N-2].qx <= 15'd16384 &&
                                          pipe_q[N-2].qy <= 15'd16384))
    else $error("normalized component exceeds one");

endmodule

// ===== tb/sv/pbpc_checker.sv =====
module pbpc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic [15:0] gain_linear_i,
  input  logic [15:0] gain_angular_i,
  input  logic [31:0] tolerance_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] w;
    logic        reached;
  } command_t;

  command_t cmd_q[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o = cmd_q.size();

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic command_t control_tick(logic [143:0] d);
    command_t c;
    longint e[8];
    longint unsigned sum, n2;
    longint x, y, z, t, xs, ys, dx, dy, w, s, at;
    c = '0;
    e[0] = longint'($signed(d[15:0]));
    e[1] = longint'($signed(d[31:16]));
    e[2] = longint'($signed(d[47:32]));
    for (int i = 0; i < 5; i++) e[3+i] = longint'($signed(d[64+16*i +: 16]));
    sum = 0;
    for (int i = 0; i < pbpc_pkg::ERROR_DIMENSIONS && i < 8; i++) sum += e[i] * e[i];
    if (sum < longint'(tolerance_i)) begin
      c.reached = 1'b1;
      return c;
    end
    x = e[0] * 65536;
    y = e[1] * 65536;
    z = -longint'($signed(d[63:48])) * 65536;
    if (z > 843314857) z -= 1686629713;
    else if (z < -843314857) z += 1686629713;
    if (z > 421657428) begin
      t = x; x = -y; y = t; z -= 421657428;
    end else if (z < -421657428) begin
      t = x; x = y; y = -t; z += 421657428;
    end
    for (int i = 0; i < pbpc_pkg::CORDIC_STAGES && i < 24; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      case (i)
        0: at = 210828714; 1: at = 124459457; 2: at = 65760959;
        3: at = 33381290; 4: at = 16755422; 5: at = 8385879;
        6: at = 4193963; 7: at = 2097109; 8: at = 1048571;
        9: at = 524287;
        default: at = 64'sd1 <<< (28 - i);
      endcase
      if (z >= 0) begin
        x -= ys; y += xs; z -= at;
      end else begin
        x += ys; y -= xs; z += at;
      end
    end
    x = shr(shr(x, 12) * 652032874, 30);
    y = shr(shr(y, 12) * 652032874, 30);
    dx = shr(x * longint'(gain_linear_i), 8);
    dy = shr(y * longint'(gain_linear_i), 8);
    n2 = dx * dx + dy * dy;
    if (n2 > (64'd1 << 32)) begin
      s = root64(n2);
      dx = (dx * 16384) / s;
      dy = (dy * 16384) / s;
    end else begin
      dx = shr(dx, 2);
      dy = shr(dy, 2);
    end
    w = shr(e[2] * longint'(gain_angular_i), 6);
    if (w > 16384) w = 16384;
    else if (w < -16384) w = -16384;
    c.vx = dx[15:0];
    c.vy = dy[15:0];
    c.w = w[15:0];
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    command_t exp_c;
    if (!rst_ni) begin
      fails <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        cmd_q.insert(cmd_q.size(), control_tick(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
          fails <= fails + 1;
        end else begin
          exp_c = cmd_q.pop_front();
          if (exp_c.vx !== m_axis_tdata[15:0] || exp_c.vy !== m_axis_tdata[31:16] ||
              exp_c.w !== m_axis_tdata[47:32] || exp_c.reached !== m_axis_tuser) begin
            $display("%0t: mismatch expected vx %h vy %h w %h r %b, got vx %h vy %h w %h r %b",
                     $time, exp_c.vx, exp_c.vy, exp_c.w, exp_c.reached,
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                     m_axis_tuser);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [143:0] s_axis_tdata;
  logic [47:0] m_axis_tdata;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic [15:0] gain_lin, gain_ang;
  logic [31:0] tol;
  int fail_count, pending, idle_cycles;
  bit hold_off;

  planar_base_p_controller_unit dut (.*);

  pbpc_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .gain_linear_i(gain_lin), .gain_angular_i(gain_ang), .tolerance_i(tol),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick16(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 200)) - 100);
      4: return 16'(signed'($urandom_range(0, 16000)) - 8000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      pbpc_pkg::REG_GAIN_LINEAR:  gain_lin = val[15:0];
      pbpc_pkg::REG_GAIN_ANGULAR: gain_ang = val[15:0];
      pbpc_pkg::REG_TOLERANCE:    tol = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic gap(int chance);
    int n;
    if ($urandom_range(0, 99) < chance) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send(logic [143:0] d, int chance);
    gap(chance);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int chance);
    logic [143:0] d;
    int m;
    for (int k = 0; k < count; k++) begin
      m = $urandom_range(0, 9);
      for (int f = 0; f < 9; f++) d[16*f +: 16] = pick16(m < 2 ? 3 : $urandom_range(0, 5));
      send(d, chance);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 0;
    else if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [143:0] d;
    rst_ni = 0; hold_off = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    gain_lin = 16'd2560; gain_ang = 16'd2560; tol = 32'd167772;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int k = 0; k < 20; k++) begin
      for (int f = 0; f < 9; f++) d[16*f +: 16] = pick16(k < 3 ? k : (k < 6 ? 3 : 5));
      if (k == 6) d = '0;
      if (k == 7) d = {16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h3244, 16'h0, 16'h0, 16'h1000};
      if (k == 8) d = {80'h0, 16'h8000, 16'h0, 16'h0, 16'h1000};
      if (k == 9) d = {80'h0, 16'h7fff, 16'h0, 16'h1000, 16'h0};
      send(d, 30);
    end
    drain();
    write_reg(pbpc_pkg::REG_GAIN_LINEAR, 32'h0);
    write_reg(pbpc_pkg::REG_GAIN_ANGULAR, 32'h0);
    random_phase(30, 30);
    drain();
    write_reg(pbpc_pkg::REG_GAIN_LINEAR, 32'hffff);
    write_reg(pbpc_pkg::REG_GAIN_ANGULAR, 32'hffff);
    write_reg(pbpc_pkg::REG_TOLERANCE, 32'hffffffff);
    random_phase(40, 30);
    drain();
    write_reg(pbpc_pkg::REG_TOLERANCE, 32'h0);
    hold_off = 1;
    fork
      random_phase(90, 0);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();
    write_reg(pbpc_pkg::REG_GAIN_LINEAR, 32'h0100);
    write_reg(pbpc_pkg::REG_GAIN_ANGULAR, 32'h0040);
    write_reg(pbpc_pkg::REG_TOLERANCE, 32'd167772);
    random_phase(120, 40);
    drain();
    write_reg(pbpc_pkg::REG_GAIN_LINEAR, 32'h1234);
    write_reg(pbpc_pkg::REG_GAIN_ANGULAR, 32'h8000);
    write_reg(pbpc_pkg::REG_TOLERANCE, $urandom);
    random_phase(120, 10);
    drain();
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
